>>> sv/cbs_pkg.sv
// shared types and constants for the cubic b-spline evaluator
`default_nettype none
package cbs_pkg;
  localparam int CoordW = 24;
  localparam int OutW = 32;
  localparam int ParamW = 21;
  localparam int LimitW = 6;
  localparam logic OpWrite = 1'b0;
  localparam logic OpEval = 1'b1;
  localparam logic StatusOk = 1'b0;
  localparam logic StatusRange = 1'b1;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [OutW-1:0] out_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;
endpackage
`default_nettype wire

>>> sv/cbs_weights.sv
// fraction powers and basis weights, two register stages
`default_nettype none
module cbs_weights #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [FRAC_BITS-1:0] t,
  output logic signed [FRAC_BITS+4:0] wp [4],
  output logic signed [FRAC_BITS+4:0] wv [4],
  output logic signed [FRAC_BITS+4:0] wa [4]
);
  localparam int W = FRAC_BITS + 5;
  localparam logic signed [W-1:0] S = W'(1) <<< FRAC_BITS;
  logic [FRAC_BITS-1:0] t1;
  logic [FRAC_BITS-1:0] t2;
  logic [2*FRAC_BITS-1:0] sq;
  logic [2*FRAC_BITS-1:0] cu;
  logic signed [W-1:0] st, st2, st3;
  logic signed [W-1:0] cp [4], cv [4], ca [4];

  assign sq = t * t;
  assign cu = t2 * t1;

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= t;
      t2 <= sq[2*FRAC_BITS-1:FRAC_BITS];
    end
  end

  always_comb begin
    st = W'(t1);
    st2 = W'(t2);
    st3 = W'(cu[2*FRAC_BITS-1:FRAC_BITS]);
    cp[0] = W'(S - 3 * st + 3 * st2 - st3);
    cp[1] = W'(3 * st3 - 6 * st2 + 4 * S);
    cp[2] = W'(-3 * st3 + 3 * st2 + 3 * st + S);
    cp[3] = st3;
    cv[0] = W'(-S + 2 * st - st2);
    cv[1] = W'(3 * st2 - 4 * st);
    cv[2] = W'(-3 * st2 + 2 * st + S);
    cv[3] = st2;
    ca[0] = W'(S - st);
    ca[1] = W'(3 * st - 2 * S);
    ca[2] = W'(S - 3 * st);
    ca[3] = st;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        wp[k] <= cp[k];
        wv[k] <= cv[k];
        wa[k] <= ca[k];
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/cbs_blend.sv
// one coordinate: weight products, sums and rounding over stages
`default_nettype none
module cbs_blend #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic signed [FRAC_BITS+4:0] wp [4],
  input  wire logic signed [FRAC_BITS+4:0] wv [4],
  input  wire logic signed [FRAC_BITS+4:0] wa [4],
  input  wire cbs_pkg::coord_t        p [4],
  input  wire logic                   zero,
  output cbs_pkg::out_t               pos,
  output cbs_pkg::out_t               vel,
  output cbs_pkg::out_t               acc
);
  import cbs_pkg::*;
  localparam int PW = FRAC_BITS + 5 + CoordW;
  localparam int AW = PW + 3;
  localparam logic signed [AW-1:0] S = AW'(1) <<< FRAC_BITS;
  logic signed [PW-1:0] mp [4], mv [4], ma [4];
  logic signed [AW-1:0] sp, sv, sa;
  logic signed [AW-1:0] qp, qv, qa;
  logic signed [31:0] rq;
  logic signed [63:0] prod;
  logic signed [AW-1:0] rp;
  logic zero_d, zero_dd;
  logic signed [AW-1:0] rp_q, sv_q, sa_q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        mp[k] <= PW'(wp[k] * p[k]);
        mv[k] <= PW'(wv[k] * p[k]);
        ma[k] <= PW'(wa[k] * p[k]);
      end
      zero_d <= zero;
    end
  end

  always_comb begin
    sp = AW'(mp[0]) + AW'(mp[1]) + AW'(mp[2]) + AW'(mp[3]) + 3 * S;
    sv = AW'(mv[0]) + AW'(mv[1]) + AW'(mv[2]) + AW'(mv[3]) + S;
    sa = AW'(ma[0]) + AW'(ma[1]) + AW'(ma[2]) + AW'(ma[3]) + (S >>> 1);
  end

  // floor divides pos by 6s via shift and reciprocal, vel by 2s, acc by s
  always_ff @(posedge clk) begin
    if (en) begin
      rp_q <= sp >>> FRAC_BITS;
      sv_q <= sv >>> (FRAC_BITS + 1);
      sa_q <= sa >>> FRAC_BITS;
      zero_dd <= zero_d;
    end
  end

  always_comb begin
    rq = 32'(rp_q);
    prod = 64'(rq) * 64'sd715827883;
    rp = AW'(prod >>> 32);
    if (rp_q - rp * 6 >= 6) begin
      rp = rp + 1;
    end else if (rp_q - rp * 6 < 0) begin
      rp = rp - 1;
    end
    qp = rp;
    qv = sv_q;
    qa = sa_q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos <= zero_dd ? '0 : OutW'(qp);
      vel <= zero_dd ? '0 : OutW'(qv);
      acc <= zero_dd ? '0 : OutW'(qa);
    end
  end
endmodule
`default_nettype wire

>>> sv/cubic_bspline_evaluator.sv
// top level: point table, range check and blend pipeline
// one item accepted every cycle
// the point table reads four consecutive entries from four banks
// busy stays low; results cannot be stalled
// rst clears the valid pipeline and sets points_in_use to 32; points are not cleared
`default_nettype none
module cubic_bspline_evaluator #(
  parameter int NUM_POINTS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire logic operation,
  input  wire logic [4:0] point_index,
  input  wire cbs_pkg::coord_t point_x,
  input  wire cbs_pkg::coord_t point_y,
  input  wire cbs_pkg::coord_t point_z,
  input  wire logic [cbs_pkg::ParamW-1:0] param_u,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [cbs_pkg::LimitW-1:0] cfg_data,
  output logic      done,
  output cbs_pkg::out_t pos_x,
  output cbs_pkg::out_t pos_y,
  output cbs_pkg::out_t pos_z,
  output cbs_pkg::out_t vel_x,
  output cbs_pkg::out_t vel_y,
  output cbs_pkg::out_t vel_z,
  output cbs_pkg::out_t acc_x,
  output cbs_pkg::out_t acc_y,
  output cbs_pkg::out_t acc_z,
  output logic      status
);
  import cbs_pkg::*;
  localparam int IW = $clog2(NUM_POINTS);
  localparam int BD = (NUM_POINTS + 3) / 4;
  localparam int BW = (BD > 1) ? $clog2(BD) : 1;
  localparam int SW = ParamW - FRAC_BITS;
  localparam int CW = (SW > IW ? SW : IW) + 2;

  logic [LimitW-1:0] points_in_use;
  point_t bank [4][BD];
  point_t rd [4];
  point_t pts [4];
  logic [4:0] vld;
  logic [4:0] err;
  logic [1:0] rot;
  logic [SW-1:0] seg;
  logic [CW-1:0] seg3, lim;
  logic bad;
  logic en;
  logic signed [FRAC_BITS+4:0] wp [4], wv [4], wa [4];
  coord_t px [4], py [4], pz [4];
  logic [4:0] wr_idx;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign en = 1'b1;
  assign wr_idx = point_index;
  assign seg = param_u[ParamW-1:FRAC_BITS];
  assign seg3 = CW'(seg) + CW'(3);
  assign lim = (CW'(points_in_use) < CW'(NUM_POINTS)) ? CW'(points_in_use) : CW'(NUM_POINTS);
  assign bad = seg3 >= lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= LimitW'(32);
    end else if (cfg_valid && cfg_ready) begin
      points_in_use <= cfg_data;
    end
  end

  // banked table: bank b holds points with index mod 4 == b
  always_ff @(posedge clk) begin
    if (start && operation == OpWrite && 32'(wr_idx) < NUM_POINTS) begin
      for (int b = 0; b < 4; b++) begin
        if (wr_idx[1:0] == 2'(b)) begin
          bank[b][BW'(wr_idx >> 2)] <= '{x: point_x, y: point_y, z: point_z};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      logic [CW-1:0] a;
      a = (CW'(seg) + CW'(3 - b)) >> 2;
      if (!bad) begin
        rd[b] <= bank[b][BW'(a)];
      end
    end
    rot <= seg[1:0];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pts[k] <= rd[2'(rot + 2'(k))];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px[k] = pts[k].x;
      py[k] = pts[k].y;
      pz[k] = pts[k].z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start && operation == OpEval};
    end
    err <= {err[3:0], bad};
  end

  cbs_weights #(.FRAC_BITS(FRAC_BITS)) u_w (
    .clk(clk), .en(en), .t(param_u[FRAC_BITS-1:0]), .wp(wp), .wv(wv), .wa(wa)
  );

  cbs_blend #(.FRAC_BITS(FRAC_BITS)) u_bx (
    .clk(clk), .en(en), .wp(wp), .wv(wv), .wa(wa), .p(px), .zero(err[1]),
    .pos(pos_x), .vel(vel_x), .acc(acc_x)
  );
  cbs_blend #(.FRAC_BITS(FRAC_BITS)) u_by (
    .clk(clk), .en(en), .wp(wp), .wv(wv), .wa(wa), .p(py), .zero(err[1]),
    .pos(pos_y), .vel(vel_y), .acc(acc_y)
  );
  cbs_blend #(.FRAC_BITS(FRAC_BITS)) u_bz (
    .clk(clk), .en(en), .wp(wp), .wv(wv), .wa(wa), .p(pz), .zero(err[1]),
    .pos(pos_z), .vel(vel_z), .acc(acc_z)
  );

  assign done = vld[4];
  assign status = err[4];
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for the cubic b-spline evaluator
`timescale 1ns / 1ps
module tb_top;
  import cbs_pkg::*;

  localparam int NumPts = 32;
  localparam int FracBits = 16;
  localparam longint Scale = 64'd1 << FracBits;
  localparam int Settle = 8;
  localparam int CycleLimit = 400000;

  typedef enum logic [1:0] {KindWrite, KindEval, KindCfg, KindDrain} kind_t;

  typedef struct {
    kind_t kind;
    logic [4:0] idx;
    coord_t x, y, z;
    logic [ParamW-1:0] u;
    logic [LimitW-1:0] lim;
    int gap;
  } item_t;

  typedef struct {
    out_t v[9];
    logic st;
  } curve_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic operation = OpWrite;
  logic [4:0] point_index = '0;
  coord_t point_x = '0, point_y = '0, point_z = '0;
  logic [ParamW-1:0] param_u = '0;
  logic cfg_valid = 1'b0;
  logic [LimitW-1:0] cfg_data = '0;
  logic busy, cfg_ready, done, status;
  out_t pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;

  cubic_bspline_evaluator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .point_index(point_index), .point_x(point_x), .point_y(point_y),
    .point_z(point_z), .param_u(param_u), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .vel_x(vel_x), .vel_y(vel_y),
    .vel_z(vel_z), .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z), .status(status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  item_t pending[$];
  curve_t curve_q[$];
  int errors = 0;
  int cycles = 0;

  // predictor state
  coord_t pt_tab[NumPts][3];
  int pt_limit = 32;

  // stimulus-side bookkeeping
  bit gen_written[NumPts];
  int gen_limit = 32;
  bit no_gaps = 0;

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic curve_t blend(logic [ParamW-1:0] u);
    curve_t r;
    longint t, t2, t3, seg, lim, ap, av, aa, p;
    longint wp[4], wv[4], wa[4];
    seg = u >> FracBits;
    t = u & (Scale - 1);
    lim = (pt_limit < NumPts) ? pt_limit : NumPts;
    foreach (r.v[i]) r.v[i] = '0;
    r.st = StatusRange;
    if (seg + 3 >= lim) return r;
    r.st = StatusOk;
    t2 = (t * t) >>> FracBits;
    t3 = (t2 * t) >>> FracBits;
    wp = '{Scale - 3*t + 3*t2 - t3, 3*t3 - 6*t2 + 4*Scale,
           -3*t3 + 3*t2 + 3*t + Scale, t3};
    wv = '{-Scale + 2*t - t2, 3*t2 - 4*t, -3*t2 + 2*t + Scale, t2};
    wa = '{Scale - t, 3*t - 2*Scale, Scale - 3*t, t};
    for (int c = 0; c < 3; c++) begin
      ap = 0; av = 0; aa = 0;
      for (int k = 0; k < 4; k++) begin
        p = longint'(pt_tab[seg + k][c]);
        ap += wp[k] * p;
        av += wv[k] * p;
        aa += wa[k] * p;
      end
      r.v[c] = out_t'(floor_div(ap + 3*Scale, 6*Scale));
      r.v[3+c] = out_t'(floor_div(av + Scale, 2*Scale));
      r.v[6+c] = out_t'(floor_div(aa + Scale/2, Scale));
    end
    return r;
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return coord_t'(24'h800000);
      1: return coord_t'(24'h7fffff);
      2: return coord_t'($urandom_range(0, 2047) - 1024);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic add_write(logic [4:0] idx, coord_t x, coord_t y, coord_t z);
    item_t it;
    it = '{kind: KindWrite, idx: idx, x: x, y: y, z: z, u: '0, lim: '0, gap: draw_gap()};
    pending.push_back(it);
    gen_written[idx] = 1;
  endtask

  task automatic add_eval(logic [ParamW-1:0] u);
    item_t it;
    int seg;
    seg = u >> FracBits;
    // keep every in-range read on loaded slots
    if (seg + 3 < gen_limit)
      for (int k = 0; k < 4; k++)
        if (!gen_written[seg + k])
          add_write(5'(seg + k), rand_coord(), rand_coord(), rand_coord());
    it = '{kind: KindEval, idx: '0, x: '0, y: '0, z: '0, u: u, lim: '0, gap: draw_gap()};
    pending.push_back(it);
  endtask

  task automatic add_ctl(kind_t kind, int lim);
    item_t it;
    it = '{kind: kind, idx: '0, x: '0, y: '0, z: '0, u: '0, lim: LimitW'(lim),
           gap: Settle};
    pending.push_back(it);
    if (kind == KindCfg) gen_limit = lim;
  endtask

  function automatic logic [ParamW-1:0] mk_u(int seg, int t);
    return {5'(seg), 16'(t)};
  endfunction

  // driver
  item_t cur, sent;
  bit have_cur = 0;
  int wait_cnt = 0;

  always @(posedge clk) begin
    logic nstart, ncfg;
    curve_t r;
    cycles <= cycles + 1;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      nstart = start;
      ncfg = cfg_valid;
      if (start && !busy) begin
        nstart = 1'b0;
        if (sent.kind == KindWrite) begin
          pt_tab[sent.idx] = '{sent.x, sent.y, sent.z};
        end else begin
          r = blend(sent.u);
          curve_q.push_back(r);
        end
      end
      if (cfg_valid && cfg_ready) begin
        ncfg = 1'b0;
        pt_limit = cfg_data;
      end
      if (!nstart && !ncfg) begin
        if (!have_cur && pending.size() > 0) begin
          cur = pending.pop_front();
          have_cur = 1;
          wait_cnt = cur.gap;
        end
        if (have_cur) begin
          if (cur.kind == KindWrite || cur.kind == KindEval) begin
            if (wait_cnt > 0) begin
              wait_cnt--;
            end else begin
              operation <= (cur.kind == KindEval) ? OpEval : OpWrite;
              point_index <= cur.idx;
              point_x <= cur.x;
              point_y <= cur.y;
              point_z <= cur.z;
              param_u <= cur.u;
              sent = cur;
              nstart = 1'b1;
              have_cur = 0;
            end
          end else if (curve_q.size() == 0) begin
            if (wait_cnt > 0) begin
              wait_cnt--;
            end else begin
              if (cur.kind == KindCfg) begin
                cfg_data <= cur.lim;
                ncfg = 1'b1;
              end
              have_cur = 0;
            end
          end
        end
      end
      start <= nstart;
      cfg_valid <= ncfg;
    end
  end

  // monitor
  always @(posedge clk) begin
    curve_t exp_r;
    out_t got[9];
    if (!rst && done) begin
      got = '{pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z};
      if (curve_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transfer, status %0d", $time, status);
      end else begin
        exp_r = curve_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== exp_r.v[i]) begin
            errors++;
            $display("%0t: field %0d expected %0d actual %0d", $time, i, exp_r.v[i],
                     got[i]);
          end
        if (status !== exp_r.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int phase_lims[6];
    int n, seg;
    // directed
    add_write(0, coord_t'(24'h7fffff), coord_t'(24'h800000), coord_t'(24'h000001));
    add_write(1, coord_t'(24'h800000), coord_t'(24'h7fffff), coord_t'(24'hffffff));
    add_write(2, coord_t'(24'h7fffff), coord_t'(24'h7fffff), coord_t'(24'h800000));
    add_write(3, coord_t'(24'h800000), coord_t'(24'h800000), coord_t'(24'h7fffff));
    add_eval(mk_u(0, 0));
    add_eval(mk_u(0, 16'hffff));
    add_eval(mk_u(0, 16'h8000));
    add_eval(mk_u(0, 1));
    add_write(31, rand_coord(), rand_coord(), rand_coord());
    add_eval(mk_u(28, 16'hffff));
    add_eval(mk_u(29, 0));
    add_eval(mk_u(31, 16'hffff));
    add_ctl(KindCfg, 4);
    add_eval(mk_u(0, 16'h1234));
    add_eval(mk_u(1, 0));
    add_ctl(KindCfg, 32);
    add_eval(mk_u(28, 16'h4000));
    // random phases over several limits
    phase_lims = '{32, 4, 17, 32, 0, 31};
    for (int ph = 0; ph < 6; ph++) begin
      add_ctl(KindCfg, phase_lims[ph] == 0 ? $urandom_range(4, 32) : phase_lims[ph]);
      no_gaps = (ph == 3);
      n = 0;
      while (n < 165) begin
        if (n == 80 && ph == 2) add_ctl(KindDrain, 0);
        case ($urandom_range(0, 9))
          0, 1, 2: add_write(5'($urandom), rand_coord(), rand_coord(), rand_coord());
          3: add_eval(mk_u($urandom_range(gen_limit - 3, 31), $urandom));
          default: begin
            seg = $urandom_range(0, gen_limit - 4);
            add_eval(mk_u(seg, $urandom));
          end
        endcase
        n++;
      end
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() != 0 || have_cur || start || cfg_valid || curve_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
